FILE: hdl/rxq_pkg.sv
// Shared types and constants for the receive queue with flow control.
// Used by rxq_mem, rxq_flow and uart_receive_queue_flow_control_top.
package rxq_pkg;

	localparam int QUEUE_DEPTH_DEF = 1024;
	localparam int MAX_STOPS_DEF   = 5;
	localparam int MAX_OUT         = 64;
	localparam int MARK_W          = 11;
	localparam int CFG_DATA_W      = 11;
	localparam int CFG_INDEX_W     = 3;
	localparam logic [MARK_W-1:0] LOW_MARK_RESET = 11'd256;

	// register indexes on the write port
	localparam logic [CFG_INDEX_W-1:0] REG_HARDWARE_FLOW  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SOFTWARE_FLOW  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RECEIVE_ENABLE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_REPORT_ERRORS  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_SPACE_MARK = 3'd4;

	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic [1:0] STATUS_NORMAL  = 2'd0;
	localparam logic [1:0] STATUS_BREAK   = 2'd1;
	localparam logic [1:0] STATUS_PARITY  = 2'd2;
	localparam logic [1:0] STATUS_FRAMING = 2'd3;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_DISABLE = 3'd1,
		ACT_ENABLE  = 3'd2,
		ACT_STOP    = 3'd3,
		ACT_START   = 3'd4
	} flow_act_t;

	typedef struct packed {
		logic [2:0] errors;
		logic [7:0] data;
	} entry_t;

	typedef struct packed {
		logic              hardware_flow;
		logic              software_flow;
		logic [MARK_W-1:0] low_space_mark;
	} flow_cfg_t;

endpackage

FILE: hdl/rxq_mem.sv
// Queue storage: one write port, one read port with registered read data.
// Depends on rxq_pkg for the entry layout.
module rxq_mem
	import rxq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int PTR_W       = $clog2(QUEUE_DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [PTR_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic [PTR_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem [QUEUE_DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hdl/rxq_flow.sv
// Watermark flow control: compares free space with the low and half marks
// and holds receiver_off and the stop count. Depends on rxq_pkg.
module rxq_flow
	import rxq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int MAX_STOPS   = MAX_STOPS_DEF,
	parameter int PTR_W       = $clog2(QUEUE_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  flow_cfg_t        cfg,
	input  logic [PTR_W-1:0] space,
	input  logic             apply,
	output flow_act_t        act
);

	localparam int CMP_W = (PTR_W > MARK_W) ? PTR_W : MARK_W;
	localparam logic [PTR_W-1:0] HALF = PTR_W'(QUEUE_DEPTH / 2);
	localparam logic [2:0] STOP_CAP = 3'(MAX_STOPS);

	logic       receiver_off_q;
	logic [2:0] stops_sent_q;
	logic       off_mid, off_nxt;
	logic [2:0] stops_mid, stops_nxt;
	logic       below_low, above_half;

	assign below_low  = CMP_W'(space) < CMP_W'(cfg.low_space_mark);
	assign above_half = space > HALF;

	always_comb begin
		off_mid   = receiver_off_q;
		stops_mid = stops_sent_q;
		act       = ACT_NONE;
		// assert step first, then release step sees its outcome
		if (below_low) begin
			if (cfg.hardware_flow) begin
				if (!receiver_off_q) begin
					off_mid = 1'b1;
					act     = ACT_DISABLE;
				end
			end else if (cfg.software_flow) begin
				if (stops_sent_q <= STOP_CAP && stops_sent_q != 3'd7) begin
					stops_mid = stops_sent_q + 3'd1;
					act       = ACT_STOP;
				end
			end
		end
		off_nxt   = off_mid;
		stops_nxt = stops_mid;
		if (above_half) begin
			if (cfg.hardware_flow) begin
				if (off_mid) begin
					off_nxt = 1'b0;
					act     = ACT_ENABLE;
				end
			end else if (cfg.software_flow && stops_mid != 3'd0) begin
				stops_nxt = 3'd0;
				act       = ACT_START;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiver_off_q <= 1'b0;
			stops_sent_q   <= 3'd0;
		end else if (apply) begin
			receiver_off_q <= off_nxt;
			stops_sent_q   <= stops_nxt;
		end
	end

endmodule

FILE: hdl/uart_receive_queue_flow_control_top.sv
// Receive queue with watermark flow control: sequencer, pointers, registers.
// Depends on rxq_pkg, rxq_mem and rxq_flow.
//
// channel   direction  handshake                     payload
// command   in         start & !busy                 cmd rx_byte rx_errors room hold_off
// result    out        strobe, one cycle, no stall   has_byte out_byte out_status
//                                                    flow_action dropped last
// config    in         wr_en                         wr_index wr_data
//
// A push is a store step, then a flow check step; results that need no
// flow check leave the cycle after acceptance with busy staying low.
// In a drain the single memory read port gives one byte a cycle, and the
// flow check rides on the last byte.
// Reset clears pointers, flow state and registers; the queue memory is not
// cleared. The receiver cannot stall, so results are never held.
module uart_receive_queue_flow_control_top
	import rxq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int MAX_STOPS   = MAX_STOPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   cmd,
	input  logic [7:0]             rx_byte,
	input  logic [2:0]             rx_errors,
	input  logic [6:0]             room,
	input  logic                   hold_off,
	output logic                   strobe,
	output logic                   has_byte,
	output logic [7:0]             out_byte,
	output logic [1:0]             out_status,
	output logic [2:0]             flow_action,
	output logic                   dropped,
	output logic                   last,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W+1)'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [6:0] MAX_OUT_W = 7'(MAX_OUT);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLOW,
		ST_DRAIN
	} state_t;

	state_t          state_q;
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [6:0]      out_left_q;
	logic            drop_q;

	logic            strobe_q, has_byte_q, dropped_q, last_q;
	logic [7:0]      out_byte_q;
	logic [1:0]      out_status_q;
	flow_act_t       flow_action_q;

	logic            hardware_flow_q, software_flow_q, receive_enable_q, report_errors_q;
	logic [MARK_W-1:0] low_space_mark_q;

	logic [PTR_W:0]  used_ext;
	logic [PTR_W-1:0] used, space;
	logic [6:0]      room_c, len;
	logic            accept, mem_wr, mem_rd, flow_apply;
	entry_t          wr_entry, rd_entry;
	flow_cfg_t       flow_cfg;
	flow_act_t       act;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [1:0] map_status(input logic en, input logic [2:0] e);
		logic [1:0] st;
		st = STATUS_NORMAL;
		if (en) begin
			priority if (e[2]) st = STATUS_BREAK;
			else if (e[0])     st = STATUS_PARITY;
			else if (e[1])     st = STATUS_FRAMING;
			else               st = STATUS_NORMAL;
		end
		return st;
	endfunction

	// occupancy of the ring; one slot always stays unused
	assign used_ext = (wp_q >= rp_q) ? ({1'b0, wp_q} - {1'b0, rp_q})
	                                 : ({1'b0, wp_q} + DEPTH_EXT - {1'b0, rp_q});
	assign used  = used_ext[PTR_W-1:0];
	assign space = LAST_SLOT - used;

	assign room_c = (room > MAX_OUT_W) ? MAX_OUT_W : room;
	assign len    = ((PTR_W+1)'(used) < (PTR_W+1)'(room_c)) ? 7'(used) : room_c;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign wr_entry = '{errors: rx_errors, data: rx_byte};
	assign mem_wr   = accept && cmd == CMD_PUSH && space != '0;
	// issue a read at acceptance of a moving drain and while more bytes remain
	assign mem_rd   = (accept && cmd == CMD_DRAIN && used != '0 && receive_enable_q
	                   && !hold_off && len != 7'd0)
	               || (state_q == ST_DRAIN && out_left_q > 7'd1);
	assign flow_apply = (state_q == ST_FLOW) || (state_q == ST_DRAIN && out_left_q == 7'd1);

	assign flow_cfg = '{hardware_flow: hardware_flow_q, software_flow: software_flow_q,
	                    low_space_mark: low_space_mark_q};

	rxq_mem #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.PTR_W(PTR_W)
	) u_mem (
		.clk(clk),
		.wr_en(mem_wr),
		.wr_addr(wp_q),
		.wr_data(wr_entry),
		.rd_en(mem_rd),
		.rd_addr(rp_q),
		.rd_data(rd_entry)
	);

	rxq_flow #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.MAX_STOPS(MAX_STOPS),
		.PTR_W(PTR_W)
	) u_flow (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(flow_cfg),
		.space(space),
		.apply(flow_apply),
		.act(act)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hardware_flow_q  <= 1'b0;
			software_flow_q  <= 1'b0;
			receive_enable_q <= 1'b1;
			report_errors_q  <= 1'b0;
			low_space_mark_q <= LOW_MARK_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_HARDWARE_FLOW:  hardware_flow_q  <= wr_data[0];
				REG_SOFTWARE_FLOW:  software_flow_q  <= wr_data[0];
				REG_RECEIVE_ENABLE: receive_enable_q <= wr_data[0];
				REG_REPORT_ERRORS:  report_errors_q  <= wr_data[0];
				REG_LOW_SPACE_MARK: low_space_mark_q <= wr_data[MARK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			wp_q          <= '0;
			rp_q          <= '0;
			out_left_q    <= 7'd0;
			drop_q        <= 1'b0;
			strobe_q      <= 1'b0;
			has_byte_q    <= 1'b0;
			out_byte_q    <= 8'd0;
			out_status_q  <= STATUS_NORMAL;
			flow_action_q <= ACT_NONE;
			dropped_q     <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			strobe_q      <= 1'b0;
			has_byte_q    <= 1'b0;
			out_byte_q    <= 8'd0;
			out_status_q  <= STATUS_NORMAL;
			flow_action_q <= ACT_NONE;
			dropped_q     <= 1'b0;
			last_q        <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_PUSH) begin
							drop_q <= (space == '0);
							if (space != '0) begin
								wp_q <= next_slot(wp_q);
							end
							state_q <= ST_FLOW;
						end else if (used == '0) begin
							strobe_q <= 1'b1;
							last_q   <= 1'b1;
						end else if (!receive_enable_q) begin
							// discard the whole queue, then check flow
							wp_q    <= rp_q;
							drop_q  <= 1'b0;
							state_q <= ST_FLOW;
						end else if (hold_off || len == 7'd0) begin
							strobe_q <= 1'b1;
							last_q   <= 1'b1;
						end else begin
							rp_q       <= next_slot(rp_q);
							out_left_q <= len;
							state_q    <= ST_DRAIN;
						end
					end
				end
				ST_FLOW: begin
					strobe_q      <= 1'b1;
					flow_action_q <= act;
					dropped_q     <= drop_q;
					last_q        <= 1'b1;
					state_q       <= ST_IDLE;
				end
				ST_DRAIN: begin
					strobe_q     <= 1'b1;
					has_byte_q   <= 1'b1;
					out_byte_q   <= rd_entry.data;
					out_status_q <= map_status(report_errors_q, rd_entry.errors);
					out_left_q   <= out_left_q - 7'd1;
					if (out_left_q > 7'd1) begin
						rp_q <= next_slot(rp_q);
					end else begin
						// read pointer is final here, so the flow check is valid
						flow_action_q <= act;
						last_q        <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign strobe      = strobe_q;
	assign has_byte    = has_byte_q;
	assign out_byte    = out_byte_q;
	assign out_status  = out_status_q;
	assign flow_action = flow_action_q;
	assign dropped     = dropped_q;
	assign last        = last_q;

endmodule

FILE: tb/uart_receive_queue_flow_control_top_test.sv
// Self-checking testbench for uart_receive_queue_flow_control_top.
// Needs rxq_pkg and the RTL. A scoreboard class predicts every result of each
// accepted command; plain tasks drive commands and register writes.
`timescale 1ns / 1ps

module uart_receive_queue_flow_control_top_test;
	import rxq_pkg::*;

	localparam int DEPTH          = QUEUE_DEPTH_DEF;
	localparam int PTR_W          = $clog2(DEPTH);
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 80;

	typedef struct packed {
		logic       has;
		logic [7:0] data;
		logic [1:0] status;
		flow_act_t  act;
		logic       dropped;
		logic       last;
	} rx_result_t;

	class rxq_scoreboard;
		logic [7:0]        byte_mem [DEPTH];
		logic [2:0]        err_mem [DEPTH];
		logic [PTR_W-1:0]  wr_ptr;
		logic [PTR_W-1:0]  rd_ptr;
		logic              rx_off;
		logic [2:0]        stop_count;
		logic              hw_flow;
		logic              sw_flow;
		logic              rx_enable;
		logic              report_err;
		logic [MARK_W-1:0] low_mark;
		rx_result_t        due_results [$];
		int                fail_count;

		function new();
			wr_ptr     = '0;
			rd_ptr     = '0;
			rx_off     = 1'b0;
			stop_count = '0;
			hw_flow    = 1'b0;
			sw_flow    = 1'b0;
			rx_enable  = 1'b1;
			report_err = 1'b0;
			low_mark   = LOW_MARK_RESET;
			fail_count = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_HARDWARE_FLOW:  hw_flow = val[0];
				REG_SOFTWARE_FLOW:  sw_flow = val[0];
				REG_RECEIVE_ENABLE: rx_enable = val[0];
				REG_REPORT_ERRORS:  report_err = val[0];
				REG_LOW_SPACE_MARK: low_mark = val[MARK_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned used_count();
			logic [PTR_W-1:0] d;
			d = wr_ptr - rd_ptr;
			return d;
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction

		// Assert on low space first, then release on more than half free.
		function flow_act_t watermark_action();
			int unsigned space;
			flow_act_t   act;
			space = DEPTH - 1 - used_count();
			act = ACT_NONE;
			if (space < low_mark) begin
				if (hw_flow) begin
					if (!rx_off) begin
						rx_off = 1'b1;
						act = ACT_DISABLE;
					end
				end else if (sw_flow && stop_count <= MAX_STOPS_DEF && stop_count != 3'd7) begin
					stop_count = stop_count + 3'd1;
					act = ACT_STOP;
				end
			end
			if (space > DEPTH / 2) begin
				if (hw_flow) begin
					if (rx_off) begin
						rx_off = 1'b0;
						act = ACT_ENABLE;
					end
				end else if (sw_flow && stop_count != 3'd0) begin
					stop_count = '0;
					act = ACT_START;
				end
			end
			return act;
		endfunction

		function logic [1:0] line_status(logic [2:0] e);
			if (!report_err) return STATUS_NORMAL;
			if (e[2]) return STATUS_BREAK;
			if (e[0]) return STATUS_PARITY;
			if (e[1]) return STATUS_FRAMING;
			return STATUS_NORMAL;
		endfunction

		function void accept_command(logic c, logic [7:0] b, logic [2:0] e,
			logic [6:0] r, logic h);
			int unsigned used;
			int unsigned lim;
			int unsigned len;
			rx_result_t  res;
			res = '0;
			res.last = 1'b1;
			if (c == CMD_PUSH) begin
				if (used_count() == DEPTH - 1) begin
					res.dropped = 1'b1;
				end else begin
					byte_mem[wr_ptr] = b;
					err_mem[wr_ptr] = e;
					wr_ptr = wr_ptr + 1'b1;
				end
				res.act = watermark_action();
				due_results.push_back(res);
				return;
			end
			used = used_count();
			if (used == 0) begin
				due_results.push_back(res);
				return;
			end
			// receiver disabled: discard everything queued
			if (!rx_enable) begin
				wr_ptr = rd_ptr;
				res.act = watermark_action();
				due_results.push_back(res);
				return;
			end
			lim = (r > MAX_OUT) ? MAX_OUT : r;
			len = (used < lim) ? used : lim;
			if (h || len == 0) begin
				due_results.push_back(res);
				return;
			end
			for (int i = 0; i < len; i++) begin
				res.has = 1'b1;
				res.data = byte_mem[rd_ptr];
				res.status = line_status(err_mem[rd_ptr]);
				rd_ptr = rd_ptr + 1'b1;
				res.act = ACT_NONE;
				res.last = 1'b0;
				if (i == len - 1) begin
					res.act = watermark_action();
					res.last = 1'b1;
				end
				due_results.push_back(res);
			end
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns: %s", $time, msg);
			fail_count++;
		endtask

		task check_result(logic has, logic [7:0] data, logic [1:0] st, logic [2:0] act,
			logic drop, logic lst);
			rx_result_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing due: byte %02h last %0b",
					data, lst));
				return;
			end
			want = due_results.pop_front();
			if (has !== want.has)
				report_mismatch($sformatf("has_byte %0b, want %0b", has, want.has));
			if (data !== want.data)
				report_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
			if (st !== want.status)
				report_mismatch($sformatf("out_status %0d, want %0d", st, want.status));
			if (act !== want.act)
				report_mismatch($sformatf("flow_action %0d, want %0d", act, want.act));
			if (drop !== want.dropped)
				report_mismatch($sformatf("dropped %0b, want %0b", drop, want.dropped));
			if (lst !== want.last)
				report_mismatch($sformatf("last %0b, want %0b", lst, want.last));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic                   cmd;
	logic [7:0]             rx_byte;
	logic [2:0]             rx_errors;
	logic [6:0]             room;
	logic                   hold_off;
	logic                   strobe;
	logic                   has_byte;
	logic [7:0]             out_byte;
	logic [1:0]             out_status;
	logic [2:0]             flow_action;
	logic                   dropped;
	logic                   last;
	logic                   wr_en;
	logic [CFG_INDEX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0]  wr_data;

	rxq_scoreboard sb = new();
	int            idle_cycles = 0;
	logic          steady = 1'b0;
	int            push_pct = 60;

	uart_receive_queue_flow_control_top uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && strobe === 1'b1)
			sb.check_result(has_byte, out_byte, out_status, flow_action, dropped, last);
		if (strobe === 1'b1 || (start === 1'b1 && busy === 1'b0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int gap_len();
		int pick;
		if (steady) return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 88) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Called at a rising edge; returns at the edge where the command transferred.
	task automatic issue(logic c, logic [7:0] b, logic [2:0] e, logic [6:0] r, logic h);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		rx_byte <= b;
		rx_errors <= e;
		room <= r;
		hold_off <= h;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.accept_command(c, b, e, r, h);
	endtask

	task automatic hold_until_drained(int settle);
		start <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic configure(logic hw, logic sw, logic rxen, logic rep, logic [MARK_W-1:0] mark);
		hold_until_drained(SETTLE_CYCLES);
		write_reg(REG_HARDWARE_FLOW, CFG_DATA_W'(hw));
		write_reg(REG_SOFTWARE_FLOW, CFG_DATA_W'(sw));
		write_reg(REG_RECEIVE_ENABLE, CFG_DATA_W'(rxen));
		write_reg(REG_REPORT_ERRORS, CFG_DATA_W'(rep));
		write_reg(REG_LOW_SPACE_MARK, CFG_DATA_W'(mark));
		wr_en <= 1'b0;
	endtask

	initial begin
		int         ph;
		logic       c;
		logic [6:0] r;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_PUSH;
		rx_byte <= '0;
		rx_errors <= '0;
		room <= '0;
		hold_off <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_HARDWARE_FLOW;
		wr_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, empty drain
		issue(CMD_DRAIN, 8'h00, 3'd0, 7'd10, 1'b0);
		configure(1'b0, 1'b1, 1'b1, 1'b1, 11'd1020);
		issue(CMD_PUSH, 8'h00, 3'd0, 7'd0, 1'b0);
		issue(CMD_PUSH, 8'hFF, 3'd7, 7'd127, 1'b1);
		issue(CMD_PUSH, 8'h55, 3'd1, 7'd0, 1'b0);
		issue(CMD_PUSH, 8'hAA, 3'd2, 7'd0, 1'b0);
		issue(CMD_PUSH, 8'h81, 3'd3, 7'd0, 1'b0);
		issue(CMD_PUSH, 8'h7E, 3'd6, 7'd0, 1'b0);
		issue(CMD_PUSH, 8'h12, 3'd5, 7'd0, 1'b0);
		issue(CMD_DRAIN, 8'h00, 3'd0, 7'd64, 1'b1);
		issue(CMD_DRAIN, 8'h00, 3'd0, 7'd0, 1'b0);
		issue(CMD_DRAIN, 8'hFF, 3'd7, 7'd3, 1'b0);
		issue(CMD_DRAIN, 8'h00, 3'd0, 7'd127, 1'b0);
		issue(CMD_DRAIN, 8'h00, 3'd0, 7'd127, 1'b1);
		// both marks crossed in hardware flow
		configure(1'b1, 1'b0, 1'b1, 1'b0, 11'd1024);
		issue(CMD_PUSH, 8'h3C, 3'd4, 7'd0, 1'b0);
		issue(CMD_PUSH, 8'hC3, 3'd0, 7'd0, 1'b0);
		issue(CMD_DRAIN, 8'h00, 3'd0, 7'd1, 1'b0);
		// receiver disabled: the drain discards the queue
		configure(1'b1, 1'b1, 1'b0, 1'b1, 11'd0);
		issue(CMD_PUSH, 8'h5A, 3'd1, 7'd0, 1'b0);
		issue(CMD_DRAIN, 8'h00, 3'd0, 7'd64, 1'b0);
		issue(CMD_DRAIN, 8'h00, 3'd0, 7'd64, 1'b0);
		configure(1'b0, 1'b0, 1'b1, 1'b1, 11'd256);
		issue(CMD_PUSH, 8'hA5, 3'd2, 7'd0, 1'b0);
		issue(CMD_DRAIN, 8'h00, 3'd0, 7'd64, 1'b0);

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(1'b1, 1'b0, 1'b1, 1'b1, 11'd1024);
				1: configure(1'b0, 1'b1, 1'b1, 1'b0, 11'd0);
				2: configure(1'b0, 1'b1, 1'b1, 1'b1, 11'($urandom_range(990, 1024)));
				3: configure(1'b1, 1'b1, 1'b0, 1'b1, 11'($urandom_range(900, 1024)));
				4: configure(1'b0, 1'b0, 1'b1, 1'b1, 11'($urandom_range(0, 1024)));
				default: configure(1'($urandom), 1'($urandom), 1'b1, 1'($urandom),
					11'($urandom_range(0, 1024)));
			endcase
			steady = ($urandom_range(0, 3) == 0);
			push_pct = (ph == 3) ? 50 : $urandom_range(55, 75);
			repeat (60) begin
				c = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_DRAIN;
				case ($urandom_range(0, 9))
					0: r = 7'd0;
					1: r = 7'($urandom_range(65, 127));
					2: r = 7'd64;
					default: r = 7'($urandom_range(1, 63));
				endcase
				issue(c, 8'($urandom), 3'($urandom), r, $urandom_range(0, 6) == 0);
				// hold the sender until every due result has come
				if ($urandom_range(0, 39) == 0)
					hold_until_drained(0);
			end
			steady = 1'b0;
		end

		hold_until_drained(TAIL_CYCLES);
		if (sb.fail_count == 0 && sb.outstanding() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
hdl/rxq_pkg.sv
hdl/rxq_mem.sv
hdl/rxq_flow.sv
hdl/uart_receive_queue_flow_control_top.sv
tb/uart_receive_queue_flow_control_top_test.sv
